// File: hdl/spt_pkg.sv
// Shared types, constants and colour conversion for the sprite palette translator.
// No dependencies; every other file refers to it by scoped names.
package spt_pkg;

  // Item kinds arriving on the request channel (code 3 is unused)
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_OBJECT  = 2'd2
  } cmd_t;

  // Result kinds on the output channel
  localparam logic KIND_ATTR  = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  localparam logic [3:0] MAX_SLOTS   = 4'd15;
  localparam logic [7:0] HIDDEN_TILE = 8'd48;
  localparam logic [7:0] Y_LIMIT     = 8'd224;
  localparam logic [7:0] X_SHIFT     = 8'd8;
  localparam logic [7:0] Y_SHIFT     = 8'd16;
  localparam logic [8:0] SX_OFFSET   = 9'd24;
  localparam logic [7:0] SY_OFFSET   = 8'd8;

  localparam int IN_W  = 56;
  localparam int OUT_W = 88;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COLOR,
    ST_ATTR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;      // request taken this cycle
    logic       assign_slot; // hand out the next slot to the current palette
    logic       rd_en;       // read one palette byte
    logic [1:0] color_num;   // colour entry being read or emitted
    logic       load_color;  // load a colour result into the output register
    logic       load_attr;   // load the attribute result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hidden;
    logic mapped;
    logic slots_full;
    logic out_free;
  } dp_status_t;

  // 8-bit RGB (3:3:2) to 15-bit BGR
  function automatic logic [14:0] to_bgr15(input logic [7:0] v);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = {v[2:0], v[2:1]};
    g = {v[5:3], v[5:4]};
    b = {v[7:6], 3'b000} | {1'b0, v[7:6], 2'b00} | {4'b0000, v[7]};
    return {b, g, r};
  endfunction

endpackage

// File: hdl/spt_ctrl.sv
// Sequencing state machine for the sprite palette translator.
// Depends on spt_pkg; drives the datapath through ctrl_cmd_t.
module spt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic [1:0]             in_cmd,
  output logic                   s_tready,
  input  spt_pkg::dp_status_t    status,
  output spt_pkg::ctrl_cmd_t     cmd
);

  spt_pkg::state_t state;
  spt_pkg::state_t state_next;
  logic [1:0]      count;
  logic [1:0]      count_next;

  // State and colour counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spt_pkg::ST_IDLE;
      count <= 2'd0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    count_next      = count;
    s_tready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.assign_slot = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.color_num   = count;
    cmd.load_color  = 1'b0;
    cmd.load_attr   = 1'b0;
    case (state)
      spt_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && in_cmd == spt_pkg::CMD_OBJECT) begin
          state_next = spt_pkg::ST_LOOK;
        end
      end
      spt_pkg::ST_LOOK: begin
        // new visible palette with a free slot: claim it and fetch colour 0
        if (!status.hidden && !status.mapped && !status.slots_full) begin
          cmd.assign_slot = 1'b1;
          cmd.rd_en       = 1'b1;
          cmd.color_num   = 2'd0;
          count_next      = 2'd0;
          state_next      = spt_pkg::ST_COLOR;
        end else begin
          state_next = spt_pkg::ST_ATTR;
        end
      end
      spt_pkg::ST_COLOR: begin
        if (status.out_free) begin
          cmd.load_color = 1'b1;
          if (count == 2'd3) begin
            state_next = spt_pkg::ST_ATTR;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.color_num = count + 2'd1;
            count_next    = count + 2'd1;
          end
        end
      end
      spt_pkg::ST_ATTR: begin
        if (status.out_free) begin
          cmd.load_attr = 1'b1;
          state_next    = spt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/spt_dpath.sv
// Datapath: palette byte memory, palette-to-slot map, object decode, output register.
// Depends on spt_pkg; controlled by spt_ctrl.
module spt_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  in_cmd,
  input  logic [spt_pkg::IN_W-1:0]    in_data,
  input  spt_pkg::ctrl_cmd_t          cmd,
  output spt_pkg::dp_status_t         status,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [spt_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);

  logic [7:0]  pal_mem [128];
  logic [7:0]  rd_data;
  logic [1:0]  rd_num;
  logic [3:0]  slot_map [32];
  logic [3:0]  slots_used;
  logic [5:0]  obj_idx;
  logic [31:0] obj_word;

  logic [4:0]  pal;
  logic [7:0]  tile;
  logic [7:0]  xp;
  logic [7:0]  yp;
  logic [8:0]  sx;
  logic [7:0]  sy;
  logic [3:0]  map_entry;
  logic [4:0]  slot;
  logic [16:0] attr_a;
  logic [28:0] attr_b;
  logic        hidden;

  // Palette byte memory: write on request, registered read with its colour entry
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == spt_pkg::CMD_PALETTE) begin
      pal_mem[in_data[44:38]] <= in_data[52:45];
    end
    if (cmd.rd_en) begin
      rd_data <= pal_mem[{pal, cmd.color_num}];
      rd_num  <= cmd.color_num;
    end
  end

  // Hold the object under translation
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == spt_pkg::CMD_OBJECT) begin
      obj_idx  <= in_data[5:0];
      obj_word <= in_data[37:6];
    end
  end

  // Slot map and count: clear on reset or frame start, fill on assignment
  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && in_cmd == spt_pkg::CMD_FRAME)) begin
      for (int i = 0; i < 32; i++) begin
        slot_map[i] <= 4'd0;
      end
      slots_used <= 4'd0;
    end else if (cmd.assign_slot) begin
      slot_map[pal] <= slots_used + 4'd1;
      slots_used    <= slots_used + 4'd1;
    end
  end

  // Decode the object word
  always_comb begin
    pal       = obj_word[28:24];
    tile      = obj_word[23:16];
    xp        = obj_word[15:8] + spt_pkg::X_SHIFT;
    yp        = ~obj_word[7:0] - spt_pkg::Y_SHIFT;
    sx        = {1'b0, xp} + spt_pkg::SX_OFFSET;
    sy        = yp + spt_pkg::SY_OFFSET;
    hidden    = (tile == spt_pkg::HIDDEN_TILE) || (yp >= spt_pkg::Y_LIMIT);
    map_entry = slot_map[pal];
    // unmapped palette past the slot limit keeps its raw number
    slot      = (map_entry != 4'd0) ? {1'b0, map_entry} : pal;
    attr_a    = {slot, 1'b1, 3'b000, obj_idx, 2'b00};
    attr_b    = {1'b1, obj_word[30], obj_word[31], 6'd0, sy, 3'b000, sx};
  end

  assign status.hidden     = hidden;
  assign status.mapped     = (map_entry != 4'd0);
  assign status.slots_full = (slots_used >= spt_pkg::MAX_SLOTS);
  assign status.out_free   = !m_tvalid || m_tready;

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_color || cmd.load_attr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.load_color) begin
      m_tuser <= spt_pkg::KIND_COLOR;
      m_tlast <= 1'b0;
      m_tdata <= {6'd0, spt_pkg::to_bgr15(rd_data), rd_num, map_entry,
                  29'd0, 17'd0, 8'd0, 1'b0, obj_idx};
    end else if (cmd.load_attr) begin
      m_tuser <= spt_pkg::KIND_ATTR;
      m_tlast <= 1'b1;
      if (hidden) begin
        m_tdata <= {6'd0, 15'd0, 2'd0, 4'd0, 29'd0, 17'd0, tile, 1'b0, obj_idx};
      end else begin
        m_tdata <= {6'd0, 15'd0, 2'd0, 4'd0, attr_b, attr_a, tile, 1'b1, obj_idx};
      end
    end
  end

endmodule

// File: hdl/sprite_palette_translator_core.sv
// Top level of the sprite palette translator: controller plus datapath.
// Depends on spt_pkg, spt_ctrl and spt_dpath.
//
// Request channel s_*: s_tuser carries the item kind (frame start, palette byte
// write, object word); s_tdata carries the object index, object word, palette
// address and palette byte. Result channel m_*: m_tuser is the result kind
// (attributes or palette colour), m_tlast marks the final result of a request.
// Frame starts and palette writes give no result.
// An object is accepted, then its palette slot is looked up, then its results
// follow one after another: one attribute result, preceded by four colour
// results when it claims a new slot. The single palette-memory read port and
// the single output register keep the results to one at a time.
// The request side is ready only while no object is in progress.
// When the receiver stalls, the current result is held in the output
// register and the sequence pauses until it is taken.
// Reset clears the slot map, the slot count and the output valid flag;
// palette bytes are undefined until written.
module sprite_palette_translator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // object_index[5:0], object_word[37:6],
                                // palette_address[44:38], palette_byte[52:45]
  input  logic [1:0]  s_tuser,  // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // slot_index[5:0], shown[6], tile_number[14:7],
                                // attr_a[31:15], attr_b[60:32], palette_slot[64:61],
                                // color_number[66:65], color[81:67]
  output logic        m_tuser,  // kind[0]
  output logic        m_tlast   // last
);

  spt_pkg::ctrl_cmd_t  cmd;
  spt_pkg::dp_status_t status;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (s_tuser),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Colour results never close a request
  a_color_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == spt_pkg::KIND_COLOR |-> !m_tlast)
    else $error("colour result marked last");

  // Hidden object carries no attributes
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == spt_pkg::KIND_ATTR && !m_tdata[6] |-> m_tdata[60:15] == 46'd0)
    else $error("hidden object with non-zero attributes");

  // An accepted object blocks further requests
  a_obj_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == spt_pkg::CMD_OBJECT |=> !s_tready)
    else $error("request accepted while object in progress");

  // A result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_color || cmd.load_attr) |-> status.out_free)
    else $error("output register overwritten");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for sprite_palette_translator_core: drives request streams
// and predicts every result from a mirrored slot map and palette store.
// Depends on spt_pkg and the sprite_palette_translator_core RTL.
module tb;

  // Unused command code: the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot_index;
    logic        shown;
    logic [7:0]  tile;
    logic [16:0] attr_a;
    logic [28:0] attr_b;
    logic [3:0]  pal_slot;
    logic [1:0]  color_num;
    logic [14:0] color;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Mirrored block state
  logic [7:0] pal_bytes [128];
  bit         pal_written [128];
  logic [3:0] slot_map [32];
  logic [3:0] slots_used = '0;

  result_t expected_results [$];
  int mismatch_count = 0;
  int src_idle_pct = 37;
  int sink_idle_pct = 37;
  int sink_hold = 0;

  always #2 clk = ~clk;

  sprite_palette_translator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    foreach (slot_map[i]) slot_map[i] = '0;
    foreach (pal_written[i]) pal_written[i] = 1'b0;
  end

  // 3:3:2 arcade colour to 5:5:5 BGR; red and green widened by bit replication, blue mapped from its two bits
  function automatic logic [14:0] rgb332_to_bgr555(logic [7:0] c);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = {c[2:0], c[2:1]};
    g = {c[5:3], c[5:4]};
    b = {c[7], c[6] | c[7], c[6], 1'b0, c[7]};
    return {b, g, r};
  endfunction

  // Apply one accepted request to the mirror and queue the results it causes
  task automatic translate_request(logic [1:0] cmd, logic [5:0] idx, logic [31:0] word,
                                   logic [6:0] addr, logic [7:0] byt);
    result_t    r;
    logic [4:0] pal;
    logic [4:0] slot;
    logic [7:0] xp;
    logic [7:0] yp;
    logic [8:0] sx;
    logic [7:0] sy;
    case (cmd)
      spt_pkg::CMD_FRAME: begin
        foreach (slot_map[i]) slot_map[i] = '0;
        slots_used = '0;
      end
      spt_pkg::CMD_PALETTE: begin
        pal_bytes[addr] = byt;
        pal_written[addr] = 1'b1;
      end
      spt_pkg::CMD_OBJECT: begin
        pal = word[28:24];
        xp = word[15:8] + 8'd8;
        yp = ~word[7:0] - 8'd16;
        r = '0;
        r.kind = spt_pkg::KIND_ATTR;
        r.slot_index = idx;
        r.tile = word[23:16];
        r.last = 1'b1;
        if (word[23:16] != spt_pkg::HIDDEN_TILE && yp < spt_pkg::Y_LIMIT) begin
          if (slot_map[pal] != '0) begin
            slot = {1'b0, slot_map[pal]};
          end else if (slots_used < spt_pkg::MAX_SLOTS) begin
            // claim the next slot and emit its four colours first
            slots_used = slots_used + 4'd1;
            for (int j = 0; j < 4; j++) begin
              result_t c;
              c = '0;
              c.kind = spt_pkg::KIND_COLOR;
              c.slot_index = idx;
              c.pal_slot = slots_used;
              c.color_num = 2'(j);
              c.color = rgb332_to_bgr555(pal_bytes[7'(pal * 4 + j)]);
              expected_results.push_back(c);
            end
            slot_map[pal] = slots_used;
            slot = {1'b0, slots_used};
          end else begin
            // out of slots: keep the raw palette number
            slot = pal;
          end
          sx = {1'b0, xp} + 9'd24;
          sy = yp + 8'd8;
          r.shown = 1'b1;
          r.attr_a = {slot, 1'b1, 3'b000, idx, 2'b00};
          r.attr_b = {1'b1, word[30], word[31], 6'd0, sy, 3'd0, sx};
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Offer one request, idling at random first; valid stays high on return
  task automatic send_request(logic [1:0] cmd, logic [5:0] idx, logic [31:0] word,
                              logic [6:0] addr, logic [7:0] byt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b000, byt, addr, word, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    translate_request(cmd, idx, word, addr, byt);
  endtask

  task automatic send_frame();
    send_request(spt_pkg::CMD_FRAME, 6'($urandom), $urandom, 7'($urandom), 8'($urandom));
  endtask

  task automatic send_palette(logic [6:0] addr, logic [7:0] byt);
    send_request(spt_pkg::CMD_PALETTE, 6'($urandom), $urandom, addr, byt);
  endtask

  // Fill any unwritten entry of the palette first, so no undefined byte is read
  task automatic send_object(logic [5:0] idx, logic [31:0] word);
    for (int j = 0; j < 4; j++) begin
      if (!pal_written[7'(word[28:24] * 4 + j)])
        send_palette(7'(word[28:24] * 4 + j), 8'($urandom));
    end
    send_request(spt_pkg::CMD_OBJECT, idx, word, 7'($urandom), 8'($urandom));
  endtask

  function automatic logic [31:0] object_word(logic hflip, logic vflip, logic [4:0] pal,
                                              logic [7:0] tile, logic [7:0] x, logic [7:0] y);
    return {hflip, vflip, 1'($urandom), pal, tile, x, y};
  endfunction

  // Random word that is sure to be shown
  function automatic logic [31:0] shown_word(logic [4:0] pal);
    logic [7:0] tile;
    tile = 8'($urandom);
    if (tile == spt_pkg::HIDDEN_TILE) tile = ~tile;
    return object_word(1'($urandom), 1'($urandom), pal, tile, 8'($urandom),
                       8'($urandom_range(16, 239)));
  endfunction

  function automatic string describe_result(result_t r);
    return $sformatf({"kind=%0d idx=%0d shown=%0d tile=%0d a=%05h b=%07h ",
                      "slot=%0d cn=%0d col=%04h last=%0d"},
                     r.kind, r.slot_index, r.shown, r.tile, r.attr_a, r.attr_b,
                     r.pal_slot, r.color_num, r.color, r.last);
  endfunction

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.slot_index = m_tdata[5:0];
      got.shown = m_tdata[6];
      got.tile = m_tdata[14:7];
      got.attr_a = m_tdata[31:15];
      got.attr_b = m_tdata[60:32];
      got.pal_slot = m_tdata[64:61];
      got.color_num = m_tdata[66:65];
      got.color = m_tdata[81:67];
      got.last = m_tlast;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: %s", describe_result(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch expected: %s", describe_result(want));
            $display("           actual: %s", describe_result(got));
          end
        end
      end
    end
  end

  // Extremes of position, flips, hiding rules, slot reuse and the unused code
  task automatic test_directed();
    send_frame();
    send_palette(7'd0, 8'h00);
    send_palette(7'd1, 8'hff);
    send_palette(7'd2, 8'h55);
    send_palette(7'd3, 8'haa);
    send_palette(7'd124, 8'h07);
    send_palette(7'd125, 8'h38);
    send_palette(7'd126, 8'hc0);
    send_palette(7'd127, 8'h92);
    // new palette, lowest visible line
    send_object(6'd0, object_word(1'b0, 1'b0, 5'd0, 8'd0, 8'd0, 8'd16));
    // mapped palette, both flips, x wraps, top visible line
    send_object(6'd63, object_word(1'b1, 1'b1, 5'd0, 8'd255, 8'd255, 8'd239));
    // hidden by tile, then by y just past each end
    send_object(6'd16, object_word(1'b1, 1'b0, 5'd31, spt_pkg::HIDDEN_TILE, 8'd100, 8'd100));
    send_object(6'd17, object_word(1'b0, 1'b1, 5'd31, 8'd1, 8'd10, 8'd15));
    send_object(6'd18, object_word(1'b1, 1'b1, 5'd31, 8'd2, 8'd20, 8'd240));
    send_object(6'd15, object_word(1'b0, 1'b0, 5'd31, 8'd255, 8'd248, 8'd128));
    send_request(CMD_UNUSED, 6'h3f, 32'hffff_ffff, 7'h7f, 8'hff);
    // a new frame forgets the map, so the palette claims slot one again
    send_frame();
    send_object(6'd40, object_word(1'b0, 1'b0, 5'd31, 8'd0, 8'd0, 8'd0));
    send_object(6'd41, object_word(1'b1, 1'b0, 5'd31, 8'd7, 8'd7, 8'd200));
  endtask

  // Every palette in one frame, so the slots run out
  task automatic test_slot_exhaustion();
    logic [4:0] order [32];
    logic [4:0] tmp;
    int k;
    foreach (order[i]) order[i] = 5'(i);
    for (int i = 31; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    send_frame();
    foreach (order[i]) send_object(6'($urandom), shown_word(order[i]));
    send_object(6'($urandom), shown_word(order[0]));
    send_object(6'($urandom), shown_word(order[31]));
  endtask

  // Hold the receiver off while new palettes keep the block busy
  task automatic test_backpressure();
    send_frame();
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_object(6'($urandom), shown_word(5'($urandom)));
  endtask

  // Well-formed frames with random content and a little noise
  task automatic test_random_frames(int n_items);
    int sent;
    int pick;
    logic [31:0] word;
    sent = 0;
    while (sent < n_items) begin
      send_frame();
      sent++;
      repeat ($urandom_range(5, 40)) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          word = $urandom;
          if ($urandom_range(9) == 0) word[23:16] = spt_pkg::HIDDEN_TILE;
          send_object(6'($urandom), word);
          sent++;
        end else if (pick < 85) begin
          send_palette(7'($urandom), 8'($urandom));
          sent++;
        end else if (pick < 90) begin
          send_request(CMD_UNUSED, 6'($urandom), $urandom, 7'($urandom), 8'($urandom));
        end else begin
          send_object(6'($urandom), shown_word(5'($urandom)));
          sent++;
        end
      end
    end
  endtask

  // Both sides at full rate
  task automatic test_no_idle();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_frames(20);
    src_idle_pct = 37;
    sink_idle_pct = 37;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slot_exhaustion();
    test_backpressure();
    test_random_frames(40);
    test_no_idle();
    test_random_frames(20);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
